/* rtl/daily_light_schedule_ramp_macros.svh */
// Assertion macros shared by the schedule ramp RTL.
`ifndef DAILY_LIGHT_SCHEDULE_RAMP_MACROS_SVH
`define DAILY_LIGHT_SCHEDULE_RAMP_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define DLSR_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Check a condition that holds on every clock edge outside reset.
`define DLSR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`endif

/* rtl/dlsr_pkg.sv */
// Package with shared constants and types for the schedule ramp block.
`default_nettype none
package dlsr_pkg;
    localparam int MaxEntries = 16;
    localparam int IdxW       = $clog2(MaxEntries);
    localparam int MinW       = 11;
    localparam int LvlW       = 16;
    localparam int EntW       = MinW + LvlW + MinW;
    localparam int WakeW      = 27;
    localparam int CntW       = 5;
    localparam logic [1:0] PhaseIdle = 2'd0;
    localparam logic [1:0] PhaseRamp = 2'd1;
    localparam logic [1:0] PhaseWait = 2'd2;
    localparam logic OpLoad = 1'b0;
    localparam logic OpTick = 1'b1;
    localparam logic [1:0] CfgCount = 2'd0;
    localparam logic [1:0] CfgLogInt = 2'd1;
    localparam logic [1:0] CfgRecheck = 2'd2;
endpackage
`default_nettype wire

/* rtl/dlsr_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module dlsr_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/dlsr_div.sv */
// Restoring divider: 33-bit dividend by 17-bit divisor, one quotient bit per cycle.
`default_nettype none
module dlsr_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [32:0] i_num,
    input  wire  [16:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quo
);
    logic [32:0] r_quo;
    logic [17:0] r_rem;
    logic [16:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [17:0] w_sh;
    logic        w_ge;
    assign w_sh = {r_rem[16:0], r_quo[32]};
    assign w_ge = w_sh >= {1'b0, r_den};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
            r_quo <= {r_quo[31:0], w_ge};
        end
    end
    // The quotient never exceeds the 16-bit level difference.
    assign o_quo = r_quo[15:0];
endmodule
`default_nettype wire

/* rtl/daily_light_schedule_ramp.sv */
// Top level of the time-of-day light schedule with linear ramps.
// A load holds busy for 1 cycle and gives no result. A tick passes SRdCur and SGetCur
// and strobes its result from SOut; with two or more entries it also reads through
// SGetAux, then waits in SDiv for the divider when ramping or passes SNext, SGetNx and
// SWake when waiting. A pending rescan first walks the entries in SScan. One request at
// a time; busy drops with the result strobe. Synchronous active-low reset clears control
// state; the schedule memory is not cleared and must be loaded before use.
`default_nettype none
module daily_light_schedule_ramp (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    input  wire         i_operation,
    input  wire  [3:0]  i_entry_slot,
    input  wire  [10:0] i_entry_minute,
    input  wire  [15:0] i_entry_level,
    input  wire  [10:0] i_entry_rise_minutes,
    input  wire  [10:0] i_minute_of_day,
    input  wire  [5:0]  i_second_of_minute,
    input  wire  [31:0] i_now_seconds,
    output logic        o_result_strobe,
    output logic        o_drive_valid,
    output logic [15:0] o_drive_level,
    output logic        o_log_record,
    output logic [1:0]  o_phase,
    output logic [26:0] o_wake_delay_ms,
    output logic [3:0]  o_active_entry
);
    import dlsr_pkg::*;
`include "daily_light_schedule_ramp_macros.svh"

    // Sequencer states.
    localparam logic [3:0] SIdle  = 4'd0;
    localparam logic [3:0] SScan  = 4'd1;
    localparam logic [3:0] SRdCur = 4'd2;
    localparam logic [3:0] SGetCur= 4'd3;
    localparam logic [3:0] SGetAux= 4'd4;
    localparam logic [3:0] SDiv   = 4'd5;
    localparam logic [3:0] SNext  = 4'd6;
    localparam logic [3:0] SGetNx = 4'd7;
    localparam logic [3:0] SOut   = 4'd8;
    localparam logic [3:0] SLoad  = 4'd9;
    localparam logic [3:0] SWake  = 4'd10;

    logic [3:0]  r_state;
    logic [CntW-1:0] r_count_cfg;
    logic [15:0] r_log_int, r_recheck;
    logic [IdxW-1:0] r_idx;
    logic        r_rescan;
    logic [15:0] r_last_lvl;
    logic [31:0] r_last_time;

    // Latched request.
    logic [10:0] r_cur;
    logic [5:0]  r_sec;
    logic [31:0] r_now;
    logic [CntW-1:0] r_cnt;

    // Scan walker.
    logic [CntW-1:0] r_scan;
    logic        r_scan_rd;
    logic [IdxW-1:0] r_scan_idx;

    // Entry under work.
    logic [10:0] r_t, r_r;
    logic [15:0] r_next;
    logic [15:0] r_prev;
    logic [10:0] r_last_min;
    logic [10:0] r_nx_min;
    logic        r_up;
    logic [15:0] r_diff;
    logic [16:0] r_span;
    logic [16:0] r_s;
    logic        r_aux_step;

    // Result.
    logic        r_valid, r_logf, r_forced;
    logic [15:0] r_level;
    logic [1:0]  r_phase;
    logic [26:0] r_wake;
    logic        r_strobe;

    // Memory port.
    logic            w_we;
    logic [IdxW-1:0] w_raddr;
    logic [EntW-1:0] w_rdata;
    logic [10:0]     w_rd_min, w_rd_rise;
    logic [15:0]     w_rd_lvl;
    logic            w_div_start, w_div_done;
    logic [32:0]     w_div_num;
    logic [15:0]     w_div_quo;
    logic            w_accept;
    logic [IdxW-1:0] w_last_idx, w_prev_idx;

    assign w_accept = start && !busy;
    assign busy = (r_state != SIdle);
    assign {w_rd_min, w_rd_lvl, w_rd_rise} = w_rdata;
    assign w_we = w_accept && (i_operation == OpLoad);
    assign w_last_idx = IdxW'(r_cnt - CntW'(1));
    assign w_prev_idx = (r_idx == '0) ? w_last_idx : (r_idx - IdxW'(1));

    dlsr_ram #(.Width(EntW), .Depth(MaxEntries)) u_tab (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(i_entry_slot),
        .i_wdata({i_entry_minute, i_entry_level, i_entry_rise_minutes}),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Ramp quotient: s * diff / span, rounded up for a falling ramp.
    // The product needs 33 bits once the rise span passes about 65000 seconds.
    assign w_div_num = 33'(r_s) * 33'(r_diff) + (r_up ? 33'd0 : (33'(r_span) - 33'd1));
    dlsr_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (r_span),
        .o_done (w_div_done),
        .o_quo  (w_div_quo)
    );

    // Read address per state.
    always_comb begin
        unique case (r_state)
            SScan:   w_raddr = IdxW'(r_scan);
            SRdCur:  w_raddr = '0;
            SGetCur: w_raddr = r_aux_step ? w_prev_idx : r_idx;
            SGetAux: w_raddr = w_last_idx;
            SNext:   w_raddr = r_idx;
            default: w_raddr = r_idx;
        endcase
    end

    logic [12:0] w_tr;
    logic        w_in_rise;
    logic [16:0] w_s_raw;
    logic [16:0] w_span;
    assign w_tr   = 13'(r_t) + 13'(r_r);
    assign w_in_rise = (r_cur >= r_t) && (w_tr > 13'(r_cur)) && (r_r != 0);
    assign w_span = 17'(r_r) * 17'd60;
    assign w_s_raw = 17'(r_cur - r_t) * 17'd60 + 17'(r_sec);

    // Wake computation from the new entry's minute.
    logic signed [12:0] w_dm;
    logic [10:0] w_dmin;
    logic [26:0] w_wake_calc;
    assign w_dm = $signed({2'b00, r_nx_min}) - $signed({2'b00, r_cur});
    always_comb begin
        if (w_dm >= 0) w_dmin = 11'(w_dm);
        else if (w_dm + 13'sd1440 >= 0) w_dmin = 11'(w_dm + 13'sd1440);
        else w_dmin = '0;
    end
    // W*4/5*1000 = minutes * 48000.
    assign w_wake_calc = 27'(w_dmin) * 27'd48000 + 27'd100;

    logic w_log_ok;
    assign w_log_ok = r_forced ||
        ((r_level != r_last_lvl) && ((r_now - r_last_time) > 32'(r_log_int)));

    assign w_div_start = (r_state == SGetAux) && r_aux_step && w_in_rise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SIdle;
            r_count_cfg <= '0;
            r_log_int   <= 16'd600;
            r_recheck   <= 16'd10000;
            r_idx       <= '0;
            r_rescan    <= 1'b1;
            r_last_lvl  <= '0;
            r_last_time <= '0;
            r_strobe    <= 1'b0;
            r_scan_rd   <= 1'b0;
            r_aux_step  <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CfgCount:   r_count_cfg <= i_cfg_data[CntW-1:0];
                    CfgLogInt:  r_log_int   <= i_cfg_data;
                    CfgRecheck: r_recheck   <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                SIdle: begin
                    if (w_accept) begin
                        r_cur <= i_minute_of_day;
                        r_sec <= i_second_of_minute;
                        r_now <= i_now_seconds;
                        r_cnt <= (r_count_cfg > CntW'(MaxEntries)) ?
                                 CntW'(MaxEntries) : r_count_cfg;
                        if (i_operation == OpLoad) begin
                            r_rescan <= 1'b1;
                            r_state  <= SLoad;
                        end else if (r_rescan) begin
                            r_rescan  <= 1'b0;
                            r_idx     <= '0;
                            r_scan    <= '0;
                            r_scan_rd <= 1'b0;
                            r_state   <= SScan;
                        end else begin
                            r_state <= SRdCur;
                        end
                    end
                end
                SLoad: r_state <= SIdle;
                SScan: begin
                    // Data for entry r_scan_idx arrives in the cycle after its read.
                    if (r_scan_rd && (w_rd_min <= r_cur)) r_idx <= r_scan_idx;
                    r_scan_idx <= IdxW'(r_scan);
                    if (r_scan < r_cnt) begin
                        r_scan_rd <= 1'b1;
                        r_scan    <= r_scan + CntW'(1);
                    end else begin
                        r_scan_rd <= 1'b0;
                        r_state   <= SRdCur;
                    end
                end
                SRdCur: begin
                    if (r_cnt < CntW'(2)) begin
                        r_valid  <= 1'b1;
                        r_forced <= 1'b1;
                        r_phase  <= PhaseIdle;
                        r_wake   <= '0;
                        r_idx    <= r_idx;
                        r_aux_step <= 1'b0;
                        r_state  <= SGetCur;
                    end else begin
                        if (CntW'(r_idx) >= r_cnt) r_idx <= '0;
                        r_aux_step <= 1'b0;
                        r_state <= SGetCur;
                    end
                end
                SGetCur: begin
                    // Entry 0 is back for a short schedule; otherwise read the active
                    // entry, then its predecessor.
                    if (r_cnt < CntW'(2)) begin
                        r_level <= (r_cnt == CntW'(1)) ? w_rd_lvl : 16'd0;
                        r_state <= SOut;
                    end else if (r_aux_step) begin
                        r_t    <= w_rd_min;
                        r_r    <= w_rd_rise;
                        r_next <= w_rd_lvl;
                        r_aux_step <= 1'b0;
                        r_state <= SGetAux;
                    end else begin
                        r_aux_step <= 1'b1;
                    end
                end
                SGetAux: begin
                    if (!r_aux_step) begin
                        r_prev <= w_rd_lvl;
                        r_aux_step <= 1'b1;
                        r_up   <= r_next >= w_rd_lvl;
                        r_diff <= (r_next >= w_rd_lvl) ? (r_next - w_rd_lvl)
                                                       : (w_rd_lvl - r_next);
                        r_span <= w_span;
                        r_s    <= (w_s_raw > w_span) ? w_span : w_s_raw;
                    end else if (w_in_rise) begin
                        r_state <= SDiv;
                    end else begin
                        r_last_min <= w_rd_min;
                        r_state    <= SNext;
                    end
                end
                SDiv: begin
                    if (w_div_done) begin
                        r_level  <= r_up ? (r_prev + w_div_quo)
                                         : (r_prev - w_div_quo);
                        r_valid  <= 1'b1;
                        r_forced <= 1'b0;
                        r_phase  <= PhaseRamp;
                        r_wake   <= 27'(r_recheck);
                        r_state  <= SOut;
                    end
                end
                SNext: begin
                    r_phase  <= PhaseWait;
                    r_forced <= 1'b1;
                    r_level  <= '0;
                    r_valid  <= 1'b0;
                    if ((r_t <= r_cur) && ((r_idx != '0) || (r_cur < r_last_min))) begin
                        r_valid <= 1'b1;
                        r_level <= r_next;
                        r_idx   <= (CntW'(r_idx) + CntW'(1) >= r_cnt) ? '0
                                   : r_idx + IdxW'(1);
                    end
                    r_state <= SGetNx;
                end
                SGetNx: begin
                    // Read of the new index issued in this cycle.
                    r_state <= SWake;
                end
                SWake: begin
                    r_nx_min <= w_rd_min;
                    r_aux_step <= 1'b0;
                    r_state  <= SOut;
                    r_wake   <= '0;
                    r_phase  <= PhaseWait;
                    r_scan_rd <= 1'b1;
                end
                SOut: begin
                    if (r_phase == PhaseWait && r_scan_rd) begin
                        r_wake    <= w_wake_calc;
                        r_scan_rd <= 1'b0;
                    end else begin
                        if (r_valid && w_log_ok) begin
                            r_last_lvl  <= r_level;
                            r_last_time <= r_now;
                        end
                        r_logf   <= r_valid && w_log_ok;
                        r_strobe <= 1'b1;
                        r_state  <= SIdle;
                    end
                end
                default: r_state <= SIdle;
            endcase
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_drive_valid   = r_valid;
    assign o_drive_level   = r_valid ? r_level : 16'd0;
    assign o_log_record    = r_logf;
    assign o_phase         = r_phase;
    assign o_wake_delay_ms = r_wake;
    assign o_active_entry  = r_idx;

    `DLSR_ASSERT_IMPL(a_strobe_idle, i_clk, i_rst_n, o_result_strobe, !busy)
    `DLSR_ASSERT_IMPL(a_ramp_valid, i_clk, i_rst_n,
        o_result_strobe && (o_phase == PhaseRamp), o_drive_valid)
    `DLSR_ASSERT_IMPL(a_idle_wake, i_clk, i_rst_n,
        o_result_strobe && (o_phase == PhaseIdle), o_wake_delay_ms == '0)
    `DLSR_ASSERT_IMPL(a_log_needs_drive, i_clk, i_rst_n,
        o_result_strobe && o_log_record, o_drive_valid)
endmodule
`default_nettype wire

/* bench/daily_light_schedule_ramp_checker.sv */
// Checker that predicts and compares the schedule ramp tick results.
`timescale 1ns / 1ps
module daily_light_schedule_ramp_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire         i_busy,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    input  wire         i_operation,
    input  wire  [3:0]  i_entry_slot,
    input  wire  [10:0] i_entry_minute,
    input  wire  [15:0] i_entry_level,
    input  wire  [10:0] i_entry_rise_minutes,
    input  wire  [10:0] i_minute_of_day,
    input  wire  [5:0]  i_second_of_minute,
    input  wire  [31:0] i_now_seconds,
    input  wire         i_result_strobe,
    input  wire         i_drive_valid,
    input  wire  [15:0] i_drive_level,
    input  wire         i_log_record,
    input  wire  [1:0]  i_phase,
    input  wire  [26:0] i_wake_delay_ms,
    input  wire  [3:0]  i_active_entry,
    output int          o_errors,
    output int          o_pending,
    output int          o_ticks_checked
);
    import dlsr_pkg::*;

    typedef struct packed {
        logic        valid;
        logic [15:0] level;
        logic        logged;
        logic [1:0]  phase;
        logic [26:0] wake;
        logic [3:0]  entry;
    } t_drive_result;

    t_drive_result expected_drive_q[$];

    logic [10:0] sched_minute [MaxEntries];
    logic [15:0] sched_level  [MaxEntries];
    logic [10:0] sched_rise   [MaxEntries];
    logic [3:0]  cur_idx;
    logic        rescan;
    logic [15:0] logged_level;
    logic [31:0] logged_time;
    logic [4:0]  cnt_reg;
    logic [15:0] log_int;
    logic [15:0] recheck;

    initial begin
        o_errors = 0;
        o_ticks_checked = 0;
    end

    assign o_pending = expected_drive_q.size();

    // Forced logs always record; ramp logs need a new level and enough elapsed time.
    function automatic logic log_gate(input logic [15:0] lvl, input logic forced,
                                      input logic [31:0] now);
        logic [31:0] elapsed;
        elapsed = now - logged_time;
        if (forced || (lvl != logged_level && elapsed > {16'd0, log_int})) begin
            logged_level = lvl;
            logged_time  = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_tick(input logic [10:0] cur, input logic [5:0] sec,
                                input logic [31:0] now);
        int               count;
        int               idx;
        int               t;
        int               r;
        longint unsigned  span;
        longint unsigned  s;
        longint unsigned  prev;
        longint unsigned  nxt;
        longint           w;
        t_drive_result    e;
        e = '0;
        count = (cnt_reg > MaxEntries) ? MaxEntries : int'(cnt_reg);
        if (rescan) begin
            rescan  = 1'b0;
            cur_idx = '0;
            for (int i = 0; i < count; i++)
                if (sched_minute[i] <= cur) cur_idx = 4'(i);
        end
        if (count < 2) begin
            e.valid  = 1'b1;
            e.level  = (count == 1) ? sched_level[0] : 16'd0;
            e.logged = log_gate(e.level, 1'b1, now);
            e.phase  = PhaseIdle;
        end else begin
            if (int'(cur_idx) >= count) cur_idx = '0;
            idx = int'(cur_idx);
            t = int'(sched_minute[idx]);
            r = int'(sched_rise[idx]);
            if (int'(cur) >= t && t + r > int'(cur) && r > 0) begin
                // Interpolate from the previous entry; round toward the floor both ways.
                prev = sched_level[(idx + count - 1) % count];
                nxt  = sched_level[idx];
                span = longint'(r) * 60;
                s    = longint'(int'(cur) - t) * 60 + sec;
                if (s > span) s = span;
                if (nxt >= prev)
                    e.level = 16'(prev + (s * (nxt - prev)) / span);
                else
                    e.level = 16'(prev - (s * (prev - nxt) + span - 1) / span);
                e.valid  = 1'b1;
                e.logged = log_gate(e.level, 1'b0, now);
                e.phase  = PhaseRamp;
                e.wake   = 27'(recheck);
            end else begin
                if (t <= int'(cur) &&
                    (idx != 0 || cur < sched_minute[count - 1])) begin
                    e.valid  = 1'b1;
                    e.level  = sched_level[idx];
                    e.logged = log_gate(e.level, 1'b1, now);
                    cur_idx  = 4'((idx + 1) % count);
                end
                w = (longint'(sched_minute[cur_idx]) - longint'(cur)) * 60;
                if (w < 0) w += 86400;
                if (w < 0) w = 0;
                e.wake  = 27'((w * 4 / 5) * 1000 + 100);
                e.phase = PhaseWait;
            end
        end
        e.entry = cur_idx;
        expected_drive_q.push_back(e);
    endtask

    always @(posedge i_clk) begin
        t_drive_result e;
        if (!i_rst_n) begin
            cur_idx      = '0;
            rescan       = 1'b1;
            logged_level = '0;
            logged_time  = '0;
            cnt_reg      = 5'd0;
            log_int      = 16'd600;
            recheck      = 16'd10000;
            expected_drive_q.delete();
        end else begin
            if (i_result_strobe) begin
                if (expected_drive_q.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    o_errors++;
                end else begin
                    e = expected_drive_q.pop_front();
                    o_ticks_checked++;
                    if (i_drive_valid !== e.valid) begin
                        $error("drive_valid exp %0d got %0d", e.valid, i_drive_valid);
                        o_errors++;
                    end
                    if (i_drive_level !== e.level) begin
                        $error("drive_level exp %0d got %0d", e.level, i_drive_level);
                        o_errors++;
                    end
                    if (i_log_record !== e.logged) begin
                        $error("log_record exp %0d got %0d", e.logged, i_log_record);
                        o_errors++;
                    end
                    if (i_phase !== e.phase) begin
                        $error("phase exp %0d got %0d", e.phase, i_phase);
                        o_errors++;
                    end
                    if (i_wake_delay_ms !== e.wake) begin
                        $error("wake_delay_ms exp %0d got %0d", e.wake, i_wake_delay_ms);
                        o_errors++;
                    end
                    if (i_active_entry !== e.entry) begin
                        $error("active_entry exp %0d got %0d", e.entry, i_active_entry);
                        o_errors++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgCount:   cnt_reg = i_cfg_data[4:0];
                    CfgLogInt:  log_int = i_cfg_data;
                    CfgRecheck: recheck = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (i_operation == OpLoad) begin
                    sched_minute[i_entry_slot] = i_entry_minute;
                    sched_level[i_entry_slot]  = i_entry_level;
                    sched_rise[i_entry_slot]   = i_entry_rise_minutes;
                    rescan = 1'b1;
                end else begin
                    predict_tick(i_minute_of_day, i_second_of_minute, i_now_seconds);
                end
            end
        end
    end

endmodule

/* bench/daily_light_schedule_ramp_tb.sv */
// Testbench top: stimulus, configuration phases and verdict for the schedule ramp.
`timescale 1ns / 1ps
module daily_light_schedule_ramp_tb;
    import dlsr_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CfgCount;
    logic [15:0] i_cfg_data = '0;
    logic        i_operation = OpLoad;
    logic [3:0]  i_entry_slot = '0;
    logic [10:0] i_entry_minute = '0;
    logic [15:0] i_entry_level = '0;
    logic [10:0] i_entry_rise_minutes = '0;
    logic [10:0] i_minute_of_day = '0;
    logic [5:0]  i_second_of_minute = '0;
    logic [31:0] i_now_seconds = '0;
    logic        o_result_strobe;
    logic        o_drive_valid;
    logic [15:0] o_drive_level;
    logic        o_log_record;
    logic [1:0]  o_phase;
    logic [26:0] o_wake_delay_ms;
    logic [3:0]  o_active_entry;

    int errors;
    int pending;
    int ticks_checked;
    int requests_sent;
    int phases_run;
    bit quiet;          // no idle gaps while set
    logic [31:0] clock_s;

    daily_light_schedule_ramp dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_operation(i_operation), .i_entry_slot(i_entry_slot),
        .i_entry_minute(i_entry_minute), .i_entry_level(i_entry_level),
        .i_entry_rise_minutes(i_entry_rise_minutes), .i_minute_of_day(i_minute_of_day),
        .i_second_of_minute(i_second_of_minute), .i_now_seconds(i_now_seconds),
        .o_result_strobe(o_result_strobe), .o_drive_valid(o_drive_valid),
        .o_drive_level(o_drive_level), .o_log_record(o_log_record), .o_phase(o_phase),
        .o_wake_delay_ms(o_wake_delay_ms), .o_active_entry(o_active_entry)
    );

    daily_light_schedule_ramp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_operation(i_operation), .i_entry_slot(i_entry_slot),
        .i_entry_minute(i_entry_minute), .i_entry_level(i_entry_level),
        .i_entry_rise_minutes(i_entry_rise_minutes), .i_minute_of_day(i_minute_of_day),
        .i_second_of_minute(i_second_of_minute), .i_now_seconds(i_now_seconds),
        .i_result_strobe(o_result_strobe), .i_drive_valid(o_drive_valid),
        .i_drive_level(o_drive_level), .i_log_record(o_log_record), .i_phase(o_phase),
        .i_wake_delay_ms(o_wake_delay_ms), .i_active_entry(o_active_entry),
        .o_errors(errors), .o_pending(pending), .o_ticks_checked(ticks_checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #20ms;
        $display("daily_light_schedule_ramp_tb: errors");
        $finish;
    end

    // Occasionally drop start so gaps appear between requests.
    task automatic maybe_idle();
        if (!quiet && $urandom_range(99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Present one request and hold it until the block takes it; leave start high.
    task automatic send_request(input logic op, input logic [3:0] slot,
                                input logic [10:0] em, input logic [15:0] lvl,
                                input logic [10:0] rise, input logic [10:0] mod,
                                input logic [5:0] sec, input logic [31:0] now);
        maybe_idle();
        start                <= 1'b1;
        i_operation          <= op;
        i_entry_slot         <= slot;
        i_entry_minute       <= em;
        i_entry_level        <= lvl;
        i_entry_rise_minutes <= rise;
        i_minute_of_day      <= mod;
        i_second_of_minute   <= sec;
        i_now_seconds        <= now;
        do @(posedge i_clk); while (busy);
        requests_sent++;
    endtask

    task automatic load_entry(input logic [3:0] slot, input logic [10:0] em,
                              input logic [15:0] lvl, input logic [10:0] rise);
        send_request(OpLoad, slot, em, lvl, rise, 11'($urandom), 6'($urandom), $urandom);
    endtask

    task automatic tick(input logic [10:0] mod, input logic [5:0] sec,
                        input logic [31:0] now);
        send_request(OpTick, 4'($urandom), 11'($urandom), 16'($urandom), 11'($urandom),
                     mod, sec, now);
    endtask

    // Drain all results, then let a trailing load settle before touching registers.
    task automatic settle_and_write(input logic [1:0] idx, input logic [15:0] data);
        int guard;
        guard = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Sorted schedule with random content; mostly short ramps, a few long ones.
    task automatic load_schedule();
        logic [10:0] m;
        m = 11'($urandom_range(0, 90));
        for (int i = 0; i < MaxEntries; i++) begin
            load_entry(4'(i), m, 16'($urandom),
                       ($urandom_range(9) == 0) ? 11'($urandom) :
                                                  11'($urandom_range(0, 80)));
            m = m + 11'($urandom_range(1, 95));
        end
    endtask

    initial begin
        logic [10:0] minute;
        logic [15:0] li;
        logic [15:0] rc;
        logic [4:0]  cnt;
        requests_sent = 0;
        phases_run = 0;
        quiet = 1'b0;
        clock_s = 32'd1000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes of every load field, then ticks through every phase.
        quiet = 1'b1;
        for (int i = 0; i < MaxEntries; i++)
            load_entry(4'(i), (i == 15) ? 11'h7FF : 11'(i * 90),
                       i[0] ? 16'hFFFF : 16'h0000,
                       (i == 2) ? 11'd0 : (i == 1) ? 11'h7FF : 11'd60);
        tick(11'd0, 6'd0, 32'd0);                 // no entries: drive zero
        settle_and_write(CfgCount, 16'd1);
        tick(11'd700, 6'd59, 32'hFFFF_FFFF);      // single entry
        settle_and_write(CfgCount, 16'd4);
        tick(11'd100, 6'd30, 32'd5);              // entry 0 reached: wait, move to entry 1
        tick(11'd190, 6'd0, 32'd700);             // rising ramp into entry 1
        tick(11'd200, 6'd0, 32'd1400);
        tick(11'd275, 6'd63, 32'd2000);           // still ramping into entry 1
        tick(11'h7FF, 6'd0, 32'd2001);            // out-of-range minute
        tick(11'd0, 6'd0, 32'd3000);              // before first change: wrap
        settle_and_write(CfgCount, 16'd2);        // lower the count to two
        tick(11'd300, 6'd10, 32'd4000);
        quiet = 1'b0;

        // Random phases: a new setting each time, extremes among them.
        for (int ph = 0; ph < 11; ph++) begin
            case (ph)
                0: begin cnt = 5'd16; li = 16'd0;     rc = 16'd0;     end
                1: begin cnt = 5'd31; li = 16'hFFFF;  rc = 16'hFFFF;  end
                2: begin cnt = 5'd0;  li = 16'd600;   rc = 16'd10000; end
                3: begin cnt = 5'd1;  li = 16'($urandom); rc = 16'($urandom); end
                4: begin cnt = 5'd2;  li = 16'd30;    rc = 16'($urandom); end
                default: begin
                    cnt = 5'($urandom_range(2, 17));
                    li  = 16'($urandom_range(0, 900));
                    rc  = 16'($urandom);
                end
            endcase
            settle_and_write(CfgCount, {11'd0, cnt});
            settle_and_write(CfgLogInt, li);
            settle_and_write(CfgRecheck, rc);
            phases_run++;
            quiet = (ph == 6);                    // one long gap-free stretch
            if (ph % 3 != 2) load_schedule();     // otherwise keep the old table
            minute = 11'($urandom_range(0, 1439));
            for (int k = 0; k < 125; k++) begin
                clock_s = clock_s + $urandom_range(0, 400);
                if ($urandom_range(99) < 12) begin
                    load_entry(4'($urandom), 11'($urandom_range(0, 1439)), 16'($urandom),
                               11'($urandom_range(0, 120)));
                end else if ($urandom_range(99) < 6) begin
                    tick(11'($urandom), 6'($urandom), $urandom);
                end else begin
                    minute = minute + 11'($urandom_range(0, 25));
                    if (minute > 11'd1439) minute = minute - 11'd1440;
                    tick(minute, 6'($urandom_range(0, 59)), clock_s);
                end
            end
        end
        start <= 1'b0;

        begin : drain
            int guard;
            guard = 0;
            while (pending != 0 && guard < 10000) begin
                @(posedge i_clk);
                guard++;
            end
        end
        repeat (60) @(posedge i_clk);

        $display("Sent %0d requests over %0d register settings; %0d tick results checked.",
                 requests_sent, phases_run, ticks_checked);
        if (errors == 0 && pending == 0)
            $display("daily_light_schedule_ramp_tb: clean");
        else
            $display("daily_light_schedule_ramp_tb: errors");
        $finish;
    end

endmodule
